// ----- hdl/kip_pkg.sv -----
// kip_pkg: shared types and constants for the keyed idle pool.
// Used by kip_ctrl, kip_datapath, keyed_idle_pool_ttl and its checker.
`timescale 1ns / 1ps

package kip_pkg;

  localparam int DEF_POOL_DEPTH  = 16;
  localparam int DEF_KEY_BITS    = 64;
  localparam int DEF_HANDLE_BITS = 16;
  localparam int DEF_TIME_BITS   = 32;

  localparam logic [31:0] TTL_RESET = 32'd30000;
  localparam logic [4:0]  CAP_RESET = 5'd4;

  // register indexes on the configuration port
  localparam logic [1:0] REG_IDLE_TTL   = 2'd0;
  localparam logic [1:0] REG_MAX_PARKED = 2'd1;

  // release reasons
  localparam logic [2:0] RSN_EXPIRED  = 3'd0;
  localparam logic [2:0] RSN_EVICTED  = 3'd1;
  localparam logic [2:0] RSN_MEMORY   = 3'd2;
  localparam logic [2:0] RSN_CLEARED  = 3'd3;
  localparam logic [2:0] RSN_REJECTED = 3'd4;

  typedef enum logic [1:0] {
    OP_TAKE  = 2'd0,
    OP_PARK  = 2'd1,
    OP_TRIM  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PM_EXPIRE,     // drop entries idle for at least the TTL
    PM_FRONT_CAP,  // drop the oldest until the count fits the cap
    PM_FRONT_ONE,  // drop the oldest entry only
    PM_AT,         // drop the entry found by take, no release
    PM_ALL         // drop everything
  } pass_mode_t;

  typedef enum logic [3:0] {
    DC_NONE,
    DC_LOAD,
    DC_PASS_INIT,
    DC_PASS_STEP,
    DC_SRCH_INIT,
    DC_SRCH_STEP,
    DC_APPEND,
    DC_REJECT,
    DC_EMIT
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXP_INIT,
    ST_EXP_RUN,
    ST_CAP_INIT,
    ST_CAP_RUN,
    ST_DISPATCH,
    ST_SRCH_INIT,
    ST_SRCH_RUN,
    ST_TDROP_INIT,
    ST_TDROP_RUN,
    ST_FULL_INIT,
    ST_FULL_RUN,
    ST_APPEND,
    ST_CAP2_INIT,
    ST_CAP2_RUN,
    ST_ALL_INIT,
    ST_ALL_RUN,
    ST_REJECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    dp_cmd_t    cmd;
    pass_mode_t mode;
    logic [2:0] reason;
  } dp_ctl_t;

  typedef struct packed {
    op_t  op;
    logic elig;
    logic lowmem;
    logic cap_zero;   // max_parked register is zero
    logic full;       // store holds POOL_DEPTH entries
    logic pass_end;   // pass has visited every entry
    logic srch_end;   // search reached the bottom or matched
    logic hit;        // search matched on this step
    logic out_free;   // output register can load
    logic drained;    // every buffered release handed out
  } dp_stat_t;

endpackage

// ----- hdl/kip_ctrl.sv -----
// kip_ctrl: sequencer for the keyed idle pool.
// Depends on kip_pkg; drives kip_datapath through dp_ctl_t / dp_stat_t.
`timescale 1ns / 1ps

module kip_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kip_pkg::dp_stat_t stat,
  output kip_pkg::dp_ctl_t  ctl
);
  import kip_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl.cmd    = DC_NONE;
    ctl.mode   = PM_EXPIRE;
    ctl.reason = RSN_EXPIRED;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cmd    = DC_LOAD;
          state_next = ST_EXP_INIT;
        end
      end
      ST_EXP_INIT: begin
        ctl.cmd    = DC_PASS_INIT;
        ctl.mode   = PM_EXPIRE;
        state_next = ST_EXP_RUN;
      end
      ST_EXP_RUN: begin
        ctl.cmd    = DC_PASS_STEP;
        ctl.mode   = PM_EXPIRE;
        ctl.reason = RSN_EXPIRED;
        if (stat.pass_end) state_next = ST_CAP_INIT;
      end
      ST_CAP_INIT: begin
        ctl.cmd    = DC_PASS_INIT;
        ctl.mode   = PM_FRONT_CAP;
        state_next = ST_CAP_RUN;
      end
      ST_CAP_RUN: begin
        ctl.cmd    = DC_PASS_STEP;
        ctl.mode   = PM_FRONT_CAP;
        ctl.reason = RSN_EVICTED;
        if (stat.pass_end) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (stat.op)
          OP_TAKE:  state_next = stat.elig ? ST_SRCH_INIT : ST_EMIT;
          OP_PARK: begin
            if (!stat.elig || stat.cap_zero) state_next = ST_REJECT;
            else if (stat.lowmem)            state_next = ST_ALL_INIT;
            else if (stat.full)              state_next = ST_FULL_INIT;
            else                             state_next = ST_APPEND;
          end
          OP_TRIM:  state_next = stat.lowmem ? ST_ALL_INIT : ST_EMIT;
          default:  state_next = ST_ALL_INIT;
        endcase
      end
      ST_SRCH_INIT: begin
        ctl.cmd    = DC_SRCH_INIT;
        state_next = ST_SRCH_RUN;
      end
      ST_SRCH_RUN: begin
        ctl.cmd = DC_SRCH_STEP;
        if (stat.srch_end) state_next = stat.hit ? ST_TDROP_INIT : ST_EMIT;
      end
      ST_TDROP_INIT: begin
        ctl.cmd    = DC_PASS_INIT;
        ctl.mode   = PM_AT;
        state_next = ST_TDROP_RUN;
      end
      ST_TDROP_RUN: begin
        ctl.cmd  = DC_PASS_STEP;
        ctl.mode = PM_AT;
        if (stat.pass_end) state_next = ST_EMIT;
      end
      ST_FULL_INIT: begin
        ctl.cmd    = DC_PASS_INIT;
        ctl.mode   = PM_FRONT_ONE;
        state_next = ST_FULL_RUN;
      end
      ST_FULL_RUN: begin
        ctl.cmd    = DC_PASS_STEP;
        ctl.mode   = PM_FRONT_ONE;
        ctl.reason = RSN_EVICTED;
        if (stat.pass_end) state_next = ST_APPEND;
      end
      ST_APPEND: begin
        ctl.cmd    = DC_APPEND;
        state_next = ST_CAP2_INIT;
      end
      ST_CAP2_INIT: begin
        ctl.cmd    = DC_PASS_INIT;
        ctl.mode   = PM_FRONT_CAP;
        state_next = ST_CAP2_RUN;
      end
      ST_CAP2_RUN: begin
        ctl.cmd    = DC_PASS_STEP;
        ctl.mode   = PM_FRONT_CAP;
        ctl.reason = RSN_EVICTED;
        if (stat.pass_end) state_next = ST_EMIT;
      end
      ST_ALL_INIT: begin
        ctl.cmd    = DC_PASS_INIT;
        ctl.mode   = PM_ALL;
        state_next = ST_ALL_RUN;
      end
      ST_ALL_RUN: begin
        ctl.cmd    = DC_PASS_STEP;
        ctl.mode   = PM_ALL;
        ctl.reason = (stat.op == OP_CLEAR) ? RSN_CLEARED : RSN_MEMORY;
        if (stat.pass_end) state_next = (stat.op == OP_PARK) ? ST_REJECT : ST_EMIT;
      end
      ST_REJECT: begin
        ctl.cmd    = DC_REJECT;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        ctl.cmd = DC_EMIT;
        if (stat.out_free && stat.drained) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/kip_datapath.sv -----
// kip_datapath: slot store, compaction passes, search, release buffer, output register.
// Depends on kip_pkg; commanded by kip_ctrl.
`timescale 1ns / 1ps

module kip_datapath #(
  parameter int POOL_DEPTH  = kip_pkg::DEF_POOL_DEPTH,
  parameter int KEY_BITS    = kip_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = kip_pkg::DEF_HANDLE_BITS,
  parameter int TIME_BITS   = kip_pkg::DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  kip_pkg::dp_ctl_t       ctl,
  output kip_pkg::dp_stat_t      stat,
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic [1:0]             operation,
  input  logic [KEY_BITS-1:0]    match_key,
  input  logic [HANDLE_BITS-1:0] item_handle,
  input  logic                   eligible,
  input  logic                   low_memory,
  input  logic [TIME_BITS-1:0]   now_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_release,
  output logic [2:0]             release_reason,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic                   success,
  output logic [4:0]             parked_count,
  output logic                   last
);
  import kip_pkg::*;

  localparam int CW  = $clog2(POOL_DEPTH + 1);          // count width
  localparam int IW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int BD  = POOL_DEPTH + 1;                  // most releases per run
  localparam int BCW = $clog2(BD + 1);
  localparam int BIW = $clog2(BD);

  logic [KEY_BITS-1:0]    slot_key    [POOL_DEPTH];
  logic [HANDLE_BITS-1:0] slot_handle [POOL_DEPTH];
  logic [TIME_BITS-1:0]   slot_time   [POOL_DEPTH];
  logic [2:0]             buf_reason  [BD];
  logic [HANDLE_BITS-1:0] buf_handle  [BD];

  logic [31:0] idle_ttl;
  logic [4:0]  max_parked;

  op_t                    op;
  logic                   elig, lowmem;
  logic [KEY_BITS-1:0]    key;
  logic [HANDLE_BITS-1:0] hdl;
  logic [TIME_BITS-1:0]   now;

  logic [CW-1:0]  fill, rd, wr, lim, srch;
  logic [IW-1:0]  at_idx;
  pass_mode_t     mode;
  logic [BCW-1:0] bcnt, ocnt;
  logic [HANDLE_BITS-1:0] found;
  logic           ok;

  logic [CW-1:0]        cap;
  logic [IW-1:0]        ri, si;
  logic [TIME_BITS-1:0] idle;
  logic                 drop, match;

  assign cap  = (32'(max_parked) > POOL_DEPTH) ? CW'(POOL_DEPTH) : CW'(max_parked);
  assign ri   = rd[IW-1:0];
  assign si   = IW'(srch - 1'b1);
  assign idle = now - slot_time[ri];
  assign match = (srch != '0) && (slot_key[si] == key);

  always_comb begin
    case (mode)
      PM_EXPIRE:    drop = 64'(idle) >= 64'(idle_ttl);
      PM_FRONT_CAP,
      PM_FRONT_ONE: drop = rd < lim;
      PM_AT:        drop = ri == at_idx;
      default:      drop = 1'b1;
    endcase
  end

  always_comb begin
    stat.op       = op;
    stat.elig     = elig;
    stat.lowmem   = lowmem;
    stat.cap_zero = max_parked == '0;
    stat.full     = 32'(fill) >= POOL_DEPTH;
    stat.pass_end = rd == fill;
    stat.srch_end = (srch == '0) || match;
    stat.hit      = match;
    stat.out_free = !out_valid || out_ready;
    stat.drained  = ocnt == bcnt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ttl   <= TTL_RESET;
      max_parked <= CAP_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == REG_IDLE_TTL)   idle_ttl   <= cfg_data;
      if (cfg_index == REG_MAX_PARKED) max_parked <= cfg_data[4:0];
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      bcnt      <= '0;
      ocnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.cmd == DC_EMIT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready)                     out_valid <= 1'b0;
      case (ctl.cmd)
        DC_LOAD: begin
          bcnt <= '0;
          ocnt <= '0;
        end
        DC_PASS_STEP: begin
          if (rd == fill) fill <= wr;
          else if (drop && mode != PM_AT) bcnt <= bcnt + 1'b1;
        end
        DC_APPEND: fill <= fill + 1'b1;
        DC_REJECT: bcnt <= bcnt + 1'b1;
        DC_EMIT: begin
          if ((!out_valid || out_ready) && ocnt != bcnt) ocnt <= ocnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload and storage
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      DC_LOAD: begin
        op     <= op_t'(operation);
        key    <= match_key;
        hdl    <= item_handle;
        elig   <= eligible;
        lowmem <= low_memory;
        now    <= now_time;
        found  <= '0;
        ok     <= 1'b0;
      end
      DC_PASS_INIT: begin
        rd   <= '0;
        wr   <= '0;
        mode <= ctl.mode;
        if (ctl.mode == PM_FRONT_ONE) lim <= CW'(1);
        else                          lim <= (fill > cap) ? fill - cap : '0;
      end
      DC_PASS_STEP: begin
        if (rd != fill) begin
          rd <= rd + 1'b1;
          if (drop) begin
            if (mode != PM_AT) begin
              buf_reason[bcnt[BIW-1:0]] <= ctl.reason;
              buf_handle[bcnt[BIW-1:0]] <= slot_handle[ri];
            end
          end else begin
            slot_key[wr[IW-1:0]]    <= slot_key[ri];
            slot_handle[wr[IW-1:0]] <= slot_handle[ri];
            slot_time[wr[IW-1:0]]   <= slot_time[ri];
            wr <= wr + 1'b1;
          end
        end
      end
      DC_SRCH_INIT: srch <= fill;
      DC_SRCH_STEP: begin
        if (match) begin
          at_idx <= si;
          found  <= slot_handle[si];
          ok     <= 1'b1;
        end else if (srch != '0) begin
          srch <= srch - 1'b1;
        end
      end
      DC_APPEND: begin
        slot_key[fill[IW-1:0]]    <= key;
        slot_handle[fill[IW-1:0]] <= hdl;
        slot_time[fill[IW-1:0]]   <= now;
        ok <= 1'b1;
      end
      DC_REJECT: begin
        buf_reason[bcnt[BIW-1:0]] <= RSN_REJECTED;
        buf_handle[bcnt[BIW-1:0]] <= hdl;
      end
      DC_EMIT: begin
        if (!out_valid || out_ready) begin
          parked_count <= 5'(fill);
          if (ocnt != bcnt) begin
            is_release     <= 1'b1;
            release_reason <= buf_reason[ocnt[BIW-1:0]];
            out_handle     <= buf_handle[ocnt[BIW-1:0]];
            success        <= 1'b0;
            last           <= 1'b0;
          end else begin
            is_release     <= 1'b0;
            release_reason <= RSN_EXPIRED;
            out_handle     <= found;
            success        <= ok;
            last           <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/keyed_idle_pool_ttl.sv -----
// keyed_idle_pool_ttl: top level of the keyed idle pool with TTL expiry.
// Depends on kip_pkg, kip_ctrl and kip_datapath.
`timescale 1ns / 1ps
//
// Usage
//  - Input channel (in_valid/in_ready) carries one operation per transaction:
//    take, park, trim or clear, with key, handle, flags and the current time.
//  - Output channel (out_valid/out_ready) returns a run of transactions per
//    input: released handles first, then one final item with last set.
//    parked_count is the pool fill after the step, the same in every item.
//  - Configuration: cfg_wen with cfg_index 0 (idle_ttl) or 1 (max_parked);
//    other indexes are ignored. Write only while the block is idle.
// Timing
//  - One operation at a time. Each runs an expiry pass and a capacity pass
//    over the parked entries (one entry per cycle), then a dispatch step,
//    then the operation's own passes or search, then the output items,
//    one per cycle while the receiver is ready.
//  - The final item waits in the output register while the next operation
//    is accepted; a stalled receiver holds the emit phase only.
// Reset
//  - Pool empty, idle_ttl 30000, max_parked 4, no output pending.
//

module keyed_idle_pool_ttl #(
  parameter int POOL_DEPTH  = kip_pkg::DEF_POOL_DEPTH,
  parameter int KEY_BITS    = kip_pkg::DEF_KEY_BITS,
  parameter int HANDLE_BITS = kip_pkg::DEF_HANDLE_BITS,
  parameter int TIME_BITS   = kip_pkg::DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             operation,
  input  logic [KEY_BITS-1:0]    match_key,
  input  logic [HANDLE_BITS-1:0] item_handle,
  input  logic                   eligible,
  input  logic                   low_memory,
  input  logic [TIME_BITS-1:0]   now_time,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   is_release,
  output logic [2:0]             release_reason,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic                   success,
  output logic [4:0]             parked_count,
  output logic                   last
);
  import kip_pkg::*;

  dp_ctl_t  ctl;   // sequencer commands
  dp_stat_t stat;  // datapath status back

  kip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // the datapath latches the input transaction on the sequencer's load command
  kip_datapath #(
    .POOL_DEPTH  (POOL_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .operation      (operation),
    .match_key      (match_key),
    .item_handle    (item_handle),
    .eligible       (eligible),
    .low_memory     (low_memory),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_release     (is_release),
    .release_reason (release_reason),
    .out_handle     (out_handle),
    .success        (success),
    .parked_count   (parked_count),
    .last           (last)
  );

endmodule

// ----- hdl/kip_checker.sv -----
// kip_checker: port-level checks on the keyed idle pool output channel.
// Depends on kip_pkg; bound to keyed_idle_pool_ttl below.
`timescale 1ns / 1ps

module kip_checker #(
  parameter int HANDLE_BITS = kip_pkg::DEF_HANDLE_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   is_release,
  input logic [2:0]             release_reason,
  input logic [HANDLE_BITS-1:0] out_handle,
  input logic                   success,
  input logic                   last
);
  import kip_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_handle) && $stable(last))
    else $error("output changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == !is_release))
    else $error("last and is_release disagree");

  a_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> release_reason == RSN_EXPIRED)
    else $error("final item carries a reason");

  a_rel: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_release |-> !success && release_reason <= RSN_REJECTED)
    else $error("bad release item");

endmodule

bind keyed_idle_pool_ttl kip_checker #(.HANDLE_BITS(HANDLE_BITS)) u_kip_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .is_release     (is_release),
  .release_reason (release_reason),
  .out_handle     (out_handle),
  .success        (success),
  .last           (last)
);
